### rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at the same edge.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Implication checked at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/lmsdb_pkg.sv
`default_nettype none

package lmsdb_pkg;

    localparam int MATRIX_COUNT       = 8;
    localparam int COLUMNS_PER_MATRIX = 5;
    localparam int PLANE_COUNT        = 2;
    localparam int ROWS_PER_MATRIX    = 7;

    localparam int CMD_W       = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int PORT_W      = 2;
    localparam int BYTE_W      = 8;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BLANK  = 3'd4;

    localparam logic [PORT_W-1:0] PORT_SEL    = 2'd0;
    localparam logic [PORT_W-1:0] PORT_DATA   = 2'd1;
    localparam logic [PORT_W-1:0] PORT_STATUS = 2'd2;

    localparam logic [BYTE_W-1:0] BLANK_CODE_RESET = 8'd128;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_TICK_RD,
        ST_TICK_SEL,
        ST_TICK_DATA,
        ST_TICK_COL,
        ST_STATUS,
        ST_BLANK_SEL,
        ST_BLANK_DATA
    } state_t;

    typedef enum logic [2:0] {
        EM_SEL_MATRIX,
        EM_DATA_BYTE,
        EM_SEL_COLUMN,
        EM_STATUS,
        EM_BLANK_SEL,
        EM_ZERO
    } emit_t;

    typedef struct packed {
        logic  load_item;
        logic  set_pending;
        logic  clr_matrix;
        logic  inc_matrix;
        logic  clr_plane;
        logic  inc_plane;
        logic  rd_tick;
        logic  rd_draw;
        logic  wr_draw;
        logic  advance_scan;
        logic  emit;
        emit_t emit_kind;
        logic  emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             pixel_in;
        logic             plane_hit;
        logic             plane_last;
        logic             matrix_last;
        logic             out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/lmsdb_ram.sv
`default_nettype none

// Simple dual-port RAM, registered read.
module lmsdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 160
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/lmsdb_ctrl.sv
`default_nettype none

module lmsdb_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire lmsdb_pkg::dp_status_t  status,
    output lmsdb_pkg::ctrl_cmd_t        cmd
);

    lmsdb_pkg::state_t state_reg;
    lmsdb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmsdb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lmsdb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lmsdb_pkg::ST_DISPATCH;
                end
            end
            lmsdb_pkg::ST_DISPATCH:
            begin
                unique case (status.command)
                    lmsdb_pkg::CMD_TICK:   state_next = lmsdb_pkg::ST_TICK_RD;
                    lmsdb_pkg::CMD_DRAW:   state_next = status.pixel_in ?
                                               lmsdb_pkg::ST_DRAW_RD : lmsdb_pkg::ST_IDLE;
                    lmsdb_pkg::CMD_STATUS: state_next = lmsdb_pkg::ST_STATUS;
                    lmsdb_pkg::CMD_BLANK:  state_next = lmsdb_pkg::ST_BLANK_SEL;
                    default:               state_next = lmsdb_pkg::ST_IDLE;
                endcase
            end
            lmsdb_pkg::ST_DRAW_RD:
            begin
                if (status.plane_hit)
                begin
                    state_next = lmsdb_pkg::ST_DRAW_WR;
                end
                else if (status.plane_last)
                begin
                    state_next = lmsdb_pkg::ST_IDLE;
                end
            end
            lmsdb_pkg::ST_DRAW_WR:
            begin
                state_next = status.plane_last ? lmsdb_pkg::ST_IDLE : lmsdb_pkg::ST_DRAW_RD;
            end
            lmsdb_pkg::ST_TICK_RD:
            begin
                state_next = lmsdb_pkg::ST_TICK_SEL;
            end
            lmsdb_pkg::ST_TICK_SEL:
            begin
                if (status.out_free)
                begin
                    state_next = lmsdb_pkg::ST_TICK_DATA;
                end
            end
            lmsdb_pkg::ST_TICK_DATA:
            begin
                if (status.out_free)
                begin
                    state_next = status.matrix_last ? lmsdb_pkg::ST_TICK_COL
                                                    : lmsdb_pkg::ST_TICK_RD;
                end
            end
            lmsdb_pkg::ST_TICK_COL, lmsdb_pkg::ST_STATUS, lmsdb_pkg::ST_BLANK_DATA:
            begin
                if (status.out_free)
                begin
                    state_next = lmsdb_pkg::ST_IDLE;
                end
            end
            lmsdb_pkg::ST_BLANK_SEL:
            begin
                if (status.out_free)
                begin
                    state_next = lmsdb_pkg::ST_BLANK_DATA;
                end
            end
            default:
            begin
                state_next = lmsdb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        unique case (state_reg)
            lmsdb_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            lmsdb_pkg::ST_DISPATCH:
            begin
                cmd.set_pending = (status.command == lmsdb_pkg::CMD_SWAP);
                cmd.clr_matrix  = (status.command == lmsdb_pkg::CMD_TICK);
                cmd.clr_plane   = (status.command == lmsdb_pkg::CMD_DRAW);
            end
            lmsdb_pkg::ST_DRAW_RD:
            begin
                cmd.rd_draw   = status.plane_hit;
                cmd.inc_plane = !status.plane_hit && !status.plane_last;
            end
            lmsdb_pkg::ST_DRAW_WR:
            begin
                cmd.wr_draw   = 1'b1;
                cmd.inc_plane = !status.plane_last;
            end
            lmsdb_pkg::ST_TICK_RD:
            begin
                cmd.rd_tick = 1'b1;
            end
            lmsdb_pkg::ST_TICK_SEL:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = lmsdb_pkg::EM_SEL_MATRIX;
            end
            lmsdb_pkg::ST_TICK_DATA:
            begin
                cmd.emit       = status.out_free;
                cmd.emit_kind  = lmsdb_pkg::EM_DATA_BYTE;
                cmd.inc_matrix = status.out_free && !status.matrix_last;
            end
            lmsdb_pkg::ST_TICK_COL:
            begin
                cmd.emit         = status.out_free;
                cmd.emit_kind    = lmsdb_pkg::EM_SEL_COLUMN;
                cmd.emit_last    = 1'b1;
                cmd.advance_scan = status.out_free;
            end
            lmsdb_pkg::ST_STATUS:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = lmsdb_pkg::EM_STATUS;
                cmd.emit_last = 1'b1;
            end
            lmsdb_pkg::ST_BLANK_SEL:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = lmsdb_pkg::EM_BLANK_SEL;
            end
            lmsdb_pkg::ST_BLANK_DATA:
            begin
                cmd.emit      = status.out_free;
                cmd.emit_kind = lmsdb_pkg::EM_ZERO;
                cmd.emit_last = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/lmsdb_datapath.sv
`default_nettype none

module lmsdb_datapath #(
    parameter int MATRIX_COUNT       = lmsdb_pkg::MATRIX_COUNT,
    parameter int COLUMNS_PER_MATRIX = lmsdb_pkg::COLUMNS_PER_MATRIX,
    parameter int PLANE_COUNT        = lmsdb_pkg::PLANE_COUNT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [lmsdb_pkg::BYTE_W-1:0]       cfg_data,
    input  wire logic [lmsdb_pkg::IN_TDATA_W-1:0]   in_data,
    input  wire logic [lmsdb_pkg::CMD_W-1:0]        in_user,
    input  wire lmsdb_pkg::ctrl_cmd_t               cmd,
    output lmsdb_pkg::dp_status_t                   status,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [lmsdb_pkg::BYTE_W-1:0]            out_data,
    output logic [lmsdb_pkg::PORT_W-1:0]            out_user,
    output logic                                    out_last
);

    localparam int PLANE_BYTES  = MATRIX_COUNT * COLUMNS_PER_MATRIX;
    localparam int BUFFER_BYTES = PLANE_COUNT * PLANE_BYTES;
    localparam int STORE_BYTES  = 2 * BUFFER_BYTES;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int COL_W        = $clog2(COLUMNS_PER_MATRIX);
    localparam int MAT_W        = $clog2(MATRIX_COUNT);
    localparam int ACROSS       = MATRIX_COUNT / 2;
    localparam int DISP_WIDTH   = ACROSS * COLUMNS_PER_MATRIX;
    localparam int DISP_HEIGHT  = 2 * lmsdb_pkg::ROWS_PER_MATRIX;

    // item fields
    logic [lmsdb_pkg::CMD_W-1:0] cmd_reg;
    logic [4:0]                  x_reg;
    logic [3:0]                  y_reg;
    logic [1:0]                  shade_reg;

    // scan state
    logic [lmsdb_pkg::BYTE_W-1:0] blank_code_reg;
    logic                         shown_reg;
    logic [COL_W-1:0]             scan_col_reg;
    logic                         scan_plane_reg;
    logic                         pending_reg;

    // loop counters
    logic [MAT_W-1:0] mat_reg;
    logic             plane_reg;

    // store
    logic [STORE_BYTES-1:0]       valid_reg;
    logic                         rd_valid_reg;
    logic [lmsdb_pkg::BYTE_W-1:0] rd_data;
    logic [lmsdb_pkg::BYTE_W-1:0] rd_byte;
    logic [ADDR_W-1:0]            tick_addr;
    logic [ADDR_W-1:0]            draw_addr;
    logic [ADDR_W-1:0]            rd_addr;
    logic [lmsdb_pkg::BYTE_W-1:0] wr_byte;

    // pixel decode
    logic [5:0]       x6;
    logic [1:0]       quot;
    logic [5:0]       quot_base;
    logic [5:0]       rem6;
    logic             lower_half;
    logic [2:0]       row_bit;
    logic [3:0]       row_adj;

    logic col_last;
    logic scan_plane_last;
    logic frame_end;

    // output register
    logic                         out_valid_reg;
    logic [lmsdb_pkg::BYTE_W-1:0] out_data_reg;
    logic [lmsdb_pkg::PORT_W-1:0] out_user_reg;
    logic                         out_last_reg;

    // x / C and x % C by compares, x < 4*C
    always_comb
    begin
        x6 = {1'b0, x_reg};
        if (x6 >= 6'(3 * COLUMNS_PER_MATRIX))
        begin
            quot      = 2'd3;
            quot_base = 6'(3 * COLUMNS_PER_MATRIX);
        end
        else if (x6 >= 6'(2 * COLUMNS_PER_MATRIX))
        begin
            quot      = 2'd2;
            quot_base = 6'(2 * COLUMNS_PER_MATRIX);
        end
        else if (x6 >= 6'(COLUMNS_PER_MATRIX))
        begin
            quot      = 2'd1;
            quot_base = 6'(COLUMNS_PER_MATRIX);
        end
        else
        begin
            quot      = 2'd0;
            quot_base = 6'd0;
        end
        rem6       = x6 - quot_base;
        lower_half = (y_reg >= 4'(lmsdb_pkg::ROWS_PER_MATRIX));
        row_adj    = lower_half ? (y_reg - 4'(lmsdb_pkg::ROWS_PER_MATRIX)) : y_reg;
        row_bit    = row_adj[2:0];
    end

    assign draw_addr = (shown_reg ? ADDR_W'(0) : ADDR_W'(BUFFER_BYTES))
                     + (plane_reg ? ADDR_W'(PLANE_BYTES) : ADDR_W'(0))
                     + ADDR_W'(rem6[COL_W-1:0]) * ADDR_W'(MATRIX_COUNT)
                     + ADDR_W'(quot)
                     + (lower_half ? ADDR_W'(ACROSS) : ADDR_W'(0));

    assign tick_addr = (shown_reg ? ADDR_W'(BUFFER_BYTES) : ADDR_W'(0))
                     + (scan_plane_reg ? ADDR_W'(PLANE_BYTES) : ADDR_W'(0))
                     + ADDR_W'(scan_col_reg) * ADDR_W'(MATRIX_COUNT)
                     + ADDR_W'(mat_reg);

    assign rd_addr = cmd.rd_tick ? tick_addr : draw_addr;
    assign rd_byte = rd_valid_reg ? rd_data : '0;
    assign wr_byte = rd_byte | (8'b1 << row_bit);

    lmsdb_ram #(
        .WIDTH (lmsdb_pkg::BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_draw),
        .wr_addr (draw_addr),
        .wr_data (wr_byte),
        .rd_en   (cmd.rd_tick || cmd.rd_draw),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign col_last        = (scan_col_reg == COL_W'(COLUMNS_PER_MATRIX - 1));
    assign scan_plane_last = (scan_plane_reg == 1'(PLANE_COUNT - 1));
    assign frame_end       = cmd.advance_scan && col_last && scan_plane_last;

    // item capture and config
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg   <= in_user;
            x_reg     <= in_data[4:0];
            y_reg     <= in_data[8:5];
            shade_reg <= in_data[10:9];
        end
        if (cmd.rd_tick || cmd.rd_draw)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_code_reg <= lmsdb_pkg::BLANK_CODE_RESET;
            shown_reg      <= 1'b0;
            scan_col_reg   <= '0;
            scan_plane_reg <= 1'b0;
            pending_reg    <= 1'b0;
            mat_reg        <= '0;
            plane_reg      <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                blank_code_reg <= cfg_data;
            end
            if (cmd.clr_matrix)
            begin
                mat_reg <= '0;
            end
            else if (cmd.inc_matrix)
            begin
                mat_reg <= mat_reg + MAT_W'(1);
            end
            if (cmd.clr_plane)
            begin
                plane_reg <= 1'b0;
            end
            else if (cmd.inc_plane)
            begin
                plane_reg <= 1'b1;
            end
            if (cmd.set_pending)
            begin
                pending_reg <= 1'b1;
            end
            if (cmd.wr_draw)
            begin
                valid_reg[draw_addr] <= 1'b1;
            end
            if (cmd.advance_scan)
            begin
                scan_col_reg <= col_last ? '0 : scan_col_reg + COL_W'(1);
                if (col_last)
                begin
                    scan_plane_reg <= scan_plane_last ? 1'b0 : 1'b1;
                end
            end
            // swap: old shown buffer becomes the drawing buffer and reads as zero
            if (frame_end && pending_reg)
            begin
                shown_reg   <= !shown_reg;
                pending_reg <= 1'b0;
                for (int e = 0; e < STORE_BYTES; e++)
                begin
                    if ((e >= BUFFER_BYTES) == shown_reg)
                    begin
                        valid_reg[e] <= 1'b0;
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_last_reg <= cmd.emit_last;
            unique case (cmd.emit_kind)
                lmsdb_pkg::EM_SEL_MATRIX:
                begin
                    out_user_reg <= lmsdb_pkg::PORT_SEL;
                    out_data_reg <= blank_code_reg | 8'(mat_reg);
                end
                lmsdb_pkg::EM_DATA_BYTE:
                begin
                    out_user_reg <= lmsdb_pkg::PORT_DATA;
                    out_data_reg <= ~rd_byte;
                end
                lmsdb_pkg::EM_SEL_COLUMN:
                begin
                    out_user_reg <= lmsdb_pkg::PORT_SEL;
                    out_data_reg <= 8'(scan_col_reg) << 3;
                end
                lmsdb_pkg::EM_STATUS:
                begin
                    out_user_reg <= lmsdb_pkg::PORT_STATUS;
                    out_data_reg <= 8'(pending_reg);
                end
                lmsdb_pkg::EM_BLANK_SEL:
                begin
                    out_user_reg <= lmsdb_pkg::PORT_SEL;
                    out_data_reg <= blank_code_reg;
                end
                lmsdb_pkg::EM_ZERO:
                begin
                    out_user_reg <= lmsdb_pkg::PORT_DATA;
                    out_data_reg <= '0;
                end
                default:
                begin
                    out_user_reg <= lmsdb_pkg::PORT_SEL;
                    out_data_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        status.command     = cmd_reg;
        status.pixel_in    = ({1'b0, x_reg} < 6'(DISP_WIDTH)) && (y_reg < 4'(DISP_HEIGHT));
        status.plane_hit   = shade_reg[plane_reg] && (int'(plane_reg) < PLANE_COUNT);
        status.plane_last  = (plane_reg == 1'(PLANE_COUNT - 1));
        status.matrix_last = (mat_reg == MAT_W'(MATRIX_COUNT - 1));
        status.out_free    = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

### rtl/core/led_matrix_scan_double_buffer.sv
// Tick: per matrix a store read, a select and a data byte, then the column select, marked last.
//   Draw: a read step per plane and a write per set plane; off-display pixels are dropped.
// One item in flight, results held in an output register; output stalls hold the sequencer.
// Reset (rst_n, asynchronous, active low): scan state, swap flag and output valid cleared,
//   blank code to 128; the frame store reads as zero through per-entry valid flags.
`default_nettype none

module led_matrix_scan_double_buffer #(
    parameter int MATRIX_COUNT       = lmsdb_pkg::MATRIX_COUNT,
    parameter int COLUMNS_PER_MATRIX = lmsdb_pkg::COLUMNS_PER_MATRIX,
    parameter int PLANE_COUNT        = lmsdb_pkg::PLANE_COUNT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // blank_code register write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lmsdb_pkg::BYTE_W-1:0]       cfg_data,

    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [4:0] pix_x, [8:5] pix_y, [10:9] shade, [15:11] zero
    input  wire logic [lmsdb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] command
    input  wire logic [lmsdb_pkg::CMD_W-1:0]        s_axis_tuser,

    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [7:0] value
    output logic [lmsdb_pkg::BYTE_W-1:0]            m_axis_tdata,
    // [1:0] port
    output logic [lmsdb_pkg::PORT_W-1:0]            m_axis_tuser,
    output logic                                    m_axis_tlast
);

    lmsdb_pkg::ctrl_cmd_t  cmd;
    lmsdb_pkg::dp_status_t status;

    // Register writes should land only while idle (the user's duty, not enforced); the port never stalls.
    assign cfg_ready = 1'b1;

    // Sequencer: decodes the command and walks the matrix and plane loops.
    lmsdb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Frame store, scan position, swap logic and the output register.
    lmsdb_datapath #(
        .MATRIX_COUNT       (MATRIX_COUNT),
        .COLUMNS_PER_MATRIX (COLUMNS_PER_MATRIX),
        .PLANE_COUNT        (PLANE_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### rtl/core/lmsdb_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lmsdb_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [lmsdb_pkg::BYTE_W-1:0]       m_axis_tdata,
    input wire logic [lmsdb_pkg::PORT_W-1:0]       m_axis_tuser,
    input wire logic                               m_axis_tlast
);

    // held result stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // one item at a time
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    `ASSERT_SAME(a_port_code, clk, rst_n, m_axis_tvalid, m_axis_tuser == lmsdb_pkg::PORT_SEL || m_axis_tuser == lmsdb_pkg::PORT_DATA || m_axis_tuser == lmsdb_pkg::PORT_STATUS)

    // status is a lone flag
    `ASSERT_SAME(a_status_form, clk, rst_n, m_axis_tvalid && m_axis_tuser == lmsdb_pkg::PORT_STATUS, m_axis_tlast && m_axis_tdata[7:1] == 7'd0)

endmodule

bind led_matrix_scan_double_buffer lmsdb_checker u_checker (.*);

`default_nettype wire

### verif/led_matrix_scan_double_buffer_test.sv
`default_nettype none

// Testbench for the double-buffered LED matrix scan engine.
// An initial block queues pixel commands phase by phase; a clocked driver presents them
// on the slave stream with bursts and gaps. A shadow copy of the scan engine (frame store,
// shown buffer, scan column/plane, swap flag, blank code) runs on every accepted
// transaction and queues the bus writes it expects. A clocked monitor pops that queue on
// every output transaction and compares port, value and last field by field.
// blank_code is only rewritten once the engine has gone quiet between phases.
module led_matrix_scan_double_buffer_test;
    import lmsdb_pkg::*;

    // Display geometry, derived the same way the engine lays out its store.
    localparam int DISP_WIDTH   = (MATRIX_COUNT / 2) * COLUMNS_PER_MATRIX;
    localparam int DISP_HEIGHT  = 2 * ROWS_PER_MATRIX;
    localparam int PLANE_BYTES  = MATRIX_COUNT * COLUMNS_PER_MATRIX;
    localparam int BUFFER_BYTES = PLANE_COUNT * PLANE_BYTES;
    localparam int STORE_BYTES  = 2 * BUFFER_BYTES;

    localparam logic [CMD_W-1:0] CMD_TOP = {CMD_W{1'b1}};   // highest command code

    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 40;
    // Longest silent stretch is a tick stretched by output stalls, or the
    // settle window; this is many times either.
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT  = 1500;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [4:0]       pix_x;
        logic [3:0]       pix_y;
        logic [1:0]       shade;
    } pixel_cmd_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] value;
        logic              last;
    } bus_write_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [BYTE_W-1:0]     cfg_data;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;    // [4:0] pix_x, [8:5] pix_y, [10:9] shade, rest 0
    logic [CMD_W-1:0]      s_axis_tuser;    // [2:0] command

    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BYTE_W-1:0]     m_axis_tdata;    // [7:0] value
    logic [PORT_W-1:0]     m_axis_tuser;    // [1:0] port
    logic                  m_axis_tlast;

    led_matrix_scan_double_buffer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow engine state
    logic [BYTE_W-1:0] shadow_store [STORE_BYTES];
    logic              shadow_shown;
    int                shadow_column;
    int                shadow_plane;
    logic              shadow_swap_req;
    logic [BYTE_W-1:0] shadow_blank_code;

    pixel_cmd_t pending_cmds[$];      // waiting to be driven
    bus_write_t bus_writes_due[$];    // predicted, not yet seen on the master side

    pixel_cmd_t driven_cmd;
    bit         cmd_taken;
    int         burst_left;
    int         gap_left;

    int rx_mode;
    int rx_left;
    int rx_count;

    int fail_count;
    int writes_checked;
    int swaps_done;
    int cmd_seen [8];
    int quiet_cycles;

    // Work out the bus writes for one accepted command and advance the shadow state.
    task automatic predict_scan_writes(input pixel_cmd_t c);
        int base;
        int addr;
        int bit_idx;
        int p;
        int i;
        begin
            case (c.command)
                CMD_TICK:
                begin
                    base = int'(shadow_shown) * BUFFER_BYTES + shadow_plane * PLANE_BYTES
                         + shadow_column * MATRIX_COUNT;
                    for (i = 0; i < MATRIX_COUNT; i++)
                    begin
                        bus_writes_due.push_back('{PORT_SEL, shadow_blank_code | BYTE_W'(i),
                                                   1'b0});
                        bus_writes_due.push_back('{PORT_DATA, ~shadow_store[base + i], 1'b0});
                    end
                    bus_writes_due.push_back('{PORT_SEL, BYTE_W'(shadow_column << 3), 1'b1});
                    // column, then plane, then the frame-end swap
                    shadow_column++;
                    if (shadow_column >= COLUMNS_PER_MATRIX)
                    begin
                        shadow_column = 0;
                        shadow_plane++;
                        if (shadow_plane >= PLANE_COUNT)
                        begin
                            shadow_plane = 0;
                            if (shadow_swap_req)
                            begin
                                shadow_shown = ~shadow_shown;
                                base = shadow_shown ? 0 : BUFFER_BYTES;
                                for (i = 0; i < BUFFER_BYTES; i++)
                                    shadow_store[base + i] = '0;
                                shadow_swap_req = 1'b0;
                                swaps_done++;
                            end
                        end
                    end
                end
                CMD_DRAW:
                begin
                    // off-display pixels are dropped
                    if (c.pix_x < DISP_WIDTH && c.pix_y < DISP_HEIGHT)
                    begin
                        addr = MATRIX_COUNT * (c.pix_x % COLUMNS_PER_MATRIX)
                             + c.pix_x / COLUMNS_PER_MATRIX
                             + ((c.pix_y >= ROWS_PER_MATRIX) ? 4 : 0);
                        bit_idx = c.pix_y % ROWS_PER_MATRIX;
                        base = shadow_shown ? 0 : BUFFER_BYTES;
                        for (p = 0; p < PLANE_COUNT; p++)
                            if (c.shade[p])
                                shadow_store[base + p * PLANE_BYTES + addr][bit_idx] = 1'b1;
                    end
                end
                CMD_SWAP:
                    shadow_swap_req = 1'b1;
                CMD_STATUS:
                    bus_writes_due.push_back('{PORT_STATUS, BYTE_W'(shadow_swap_req), 1'b1});
                CMD_BLANK:
                begin
                    bus_writes_due.push_back('{PORT_SEL, shadow_blank_code, 1'b0});
                    bus_writes_due.push_back('{PORT_DATA, BYTE_W'(0), 1'b1});
                end
                default:
                    ;   // reserved codes do nothing
            endcase
        end
    endtask

    function automatic pixel_cmd_t random_pixel_cmd();
        pixel_cmd_t c;
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                c.command = CMD_TICK;
            else if (r < 70)
                c.command = CMD_DRAW;
            else if (r < 77)
                c.command = CMD_SWAP;
            else if (r < 85)
                c.command = CMD_STATUS;
            else if (r < 93)
                c.command = CMD_BLANK;
            else
                c.command = CMD_W'($urandom_range(CMD_BLANK + 1, CMD_TOP));
            // mostly on-display pixels, some off the edge
            c.pix_x = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, DISP_WIDTH - 1))
                                                 : 5'($urandom_range(0, 31));
            c.pix_y = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, DISP_HEIGHT - 1))
                                                 : 4'($urandom_range(0, 15));
            c.shade = 2'($urandom_range(0, 3));
            return c;
        end
    endfunction

    // Block until nothing is queued, in flight or owed, then let the engine settle.
    task automatic wait_quiet();
        begin
            while (pending_cmds.size() != 0 || s_axis_tvalid || bus_writes_due.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_blank_code(input logic [BYTE_W-1:0] code);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= code;
            do
                @(posedge clk);
            while (!cfg_ready);
            shadow_blank_code = code;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Input side: hold until the transaction is taken, otherwise work in bursts with gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !cmd_taken))
        begin
            cmd_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                driven_cmd = pending_cmds.pop_front();
                s_axis_tdata  <= {5'b0, driven_cmd.shade, driven_cmd.pix_y, driven_cmd.pix_x};
                s_axis_tuser  <= driven_cmd.command;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Input transactions feed the shadow engine.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_scan_writes(driven_cmd);
            cmd_seen[driven_cmd.command]++;
            cmd_taken = 1'b1;
        end
    end

    // Output side stall pattern: runs of always-ready, coin-flip, one-in-four and three-in-four.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        rx_count++;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= (rx_count % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Output monitor: oldest prediction against each bus write.
    always @(posedge clk)
    begin
        bus_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (bus_writes_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected bus write port=%0d value=%02h last=%0b", $time,
                         m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = bus_writes_due.pop_front();
                writes_checked++;
                if (m_axis_tuser !== want.port)
                begin
                    fail_count++;
                    $display("%0t: port mismatch, expected %0d, got %0d", $time,
                             want.port, m_axis_tuser);
                end
                if (m_axis_tdata !== want.value)
                begin
                    fail_count++;
                    $display("%0t: value mismatch, expected %02h, got %02h", $time,
                             want.value, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last)
                begin
                    fail_count++;
                    $display("%0t: last mismatch, expected %0b, got %0b", $time,
                             want.last, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d bus writes still owed", $time,
                     bus_writes_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] code_list [RANDOM_PHASES];
        int ph;
        int n;
        int t;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_TICK;
        m_axis_tready = 1'b0;
        cmd_taken     = 1'b0;
        burst_left    = 0;
        gap_left      = 0;
        rx_mode       = 0;
        rx_left       = 0;
        rx_count      = 0;
        fail_count    = 0;
        writes_checked = 0;
        swaps_done    = 0;
        quiet_cycles  = 0;
        foreach (cmd_seen[k])
            cmd_seen[k] = 0;

        foreach (shadow_store[k])
            shadow_store[k] = '0;
        shadow_shown      = 1'b0;
        shadow_column     = 0;
        shadow_plane      = 0;
        shadow_swap_req   = 1'b0;
        shadow_blank_code = BLANK_CODE_RESET;

        code_list[0] = 8'h00;
        code_list[1] = 8'hFF;
        code_list[2] = 8'($urandom_range(0, 255));
        code_list[3] = BLANK_CODE_RESET;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset blank code: status/blank idle, pixel corners and edges,
        // off-display pixels, every shade, double swap request, draw while a swap waits,
        // reserved codes, then one full frame of ticks so the swap lands.
        pending_cmds.push_back('{CMD_STATUS, 5'd0, 4'd0, 2'd0});
        pending_cmds.push_back('{CMD_BLANK, 5'd0, 4'd0, 2'd0});
        pending_cmds.push_back('{CMD_DRAW, 5'd0, 4'd0, 2'd3});
        pending_cmds.push_back('{CMD_DRAW, 5'd19, 4'd13, 2'd3});
        pending_cmds.push_back('{CMD_DRAW, 5'd20, 4'd0, 2'd3});
        pending_cmds.push_back('{CMD_DRAW, 5'd0, 4'd14, 2'd3});
        pending_cmds.push_back('{CMD_DRAW, 5'd31, 4'd15, 2'd3});
        pending_cmds.push_back('{CMD_DRAW, 5'd7, 4'd6, 2'd1});
        pending_cmds.push_back('{CMD_DRAW, 5'd12, 4'd7, 2'd2});
        pending_cmds.push_back('{CMD_DRAW, 5'd3, 4'd10, 2'd0});
        pending_cmds.push_back('{CMD_SWAP, 5'd0, 4'd0, 2'd0});
        pending_cmds.push_back('{CMD_SWAP, 5'd0, 4'd0, 2'd0});
        pending_cmds.push_back('{CMD_STATUS, 5'd0, 4'd0, 2'd0});
        pending_cmds.push_back('{CMD_DRAW, 5'd10, 4'd3, 2'd3});
        pending_cmds.push_back('{CMD_BLANK + 3'd1, 5'd31, 4'd15, 2'd3});
        pending_cmds.push_back('{CMD_TOP, 5'd1, 4'd1, 2'd1});
        for (t = 0; t < COLUMNS_PER_MATRIX * PLANE_COUNT; t++)
            pending_cmds.push_back('{CMD_TICK, 5'd0, 4'd0, 2'd0});
        pending_cmds.push_back('{CMD_STATUS, 5'd0, 4'd0, 2'd0});
        wait_quiet();

        // Random part, one blank code per phase.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_blank_code(code_list[ph]);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                pending_cmds.push_back(random_pixel_cmd());
            wait_quiet();
        end

        $display("Run covered %0d ticks, %0d draws, %0d swap requests, %0d status, %0d blank,",
                 cmd_seen[CMD_TICK], cmd_seen[CMD_DRAW], cmd_seen[CMD_SWAP],
                 cmd_seen[CMD_STATUS], cmd_seen[CMD_BLANK]);
        $display("%0d reserved codes, %0d buffer swaps, %0d bus writes checked, %0d errors",
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7], swaps_done, writes_checked,
                 fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/lmsdb_pkg.sv
rtl/core/lmsdb_ram.sv
rtl/core/lmsdb_ctrl.sv
rtl/core/lmsdb_datapath.sv
rtl/core/led_matrix_scan_double_buffer.sv
rtl/core/lmsdb_checker.sv
verif/led_matrix_scan_double_buffer_test.sv
